// ----- src/sorted_key_table_macros.svh -----
// assertion macros for the sorted key table
// used by files that check their own logic; expects i_clk and i_rst_n in scope
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SKT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/skt_pkg.sv -----
// shared types and constants for the sorted key table
// no dependencies
`timescale 1ns / 1ps

package skt_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 32;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IN_DW    = 32;
    localparam int OUT_DW   = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic cmp;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

// ----- src/skt_cell.sv -----
// one cell of the sorted key row: holds one key and its compare flags
// depends on skt_pkg
`timescale 1ns / 1ps

module skt_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  skt_pkg::t_cell_ctl             i_ctl,
    input  logic                           i_occ,
    input  logic signed [skt_pkg::KEY_W-1:0] i_key,
    input  logic signed [skt_pkg::KEY_W-1:0] i_left_key,
    input  logic signed [skt_pkg::KEY_W-1:0] i_right_key,
    input  logic                           i_prev_lt,
    output logic signed [skt_pkg::KEY_W-1:0] o_key,
    output logic                           o_lt,
    output logic                           o_eq,
    output logic                           o_bnd
);
    import skt_pkg::*;

    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] n_key;
    logic                    r_lt;
    logic                    r_eq;
    logic                    w_bnd;

    // first cell not below the key: left neighbor below, this one not
    assign w_bnd = i_prev_lt && !r_lt;

    // compare flags against the broadcast key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_lt <= i_occ && (r_key < i_key);
            r_eq <= i_occ && (r_key == i_key);
        end
    end

    // insert opens a gap by shifting up, delete closes it by shifting down
    always_comb begin
        n_key = r_key;
        if (i_ctl.ins) begin
            if (w_bnd) begin
                n_key = i_key;
            end else if (!r_lt) begin
                n_key = i_left_key;
            end
        end else if (i_ctl.del) begin
            if (!r_lt) begin
                n_key = i_right_key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key = r_key;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;
    assign o_bnd = w_bnd;

endmodule

// ----- src/sorted_key_table.sv -----
// Sorted key table: a row of key cells kept in ascending order.
// Input channel s_axis: tuser carries the operation (insert, search, delete,
// clear), tdata the signed 32-bit key. Output channel m_axis: tuser carries
// the status (done or found, not found, table full), tdata the position and
// the entry count after the operation.
// Each accepted item gives exactly one result item.
// Sequence: the item is taken in the idle state, every cell then compares its
// key with the item's key in the compare state, and in the update state the
// row shifts by one place (up on insert, down on delete) while the result is
// loaded into the output register. The input is ready only in the idle state,
// so a new item is taken only once the last one has been through the update.
// The output register parts the two sides: the next item is taken while a
// result still waits. If the receiver stalls with a result pending, the
// shift step of the next item holds until the register frees up.
// Reset empties the table at once (the count is cleared; stored keys are
// only read below the count) and drops any pending result.
// depends on skt_pkg, skt_cell and sorted_key_table_macros.svh
`timescale 1ns / 1ps

module sorted_key_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [skt_pkg::IN_DW-1:0]   s_axis_tdata,  // key[31:0]
    input  logic [skt_pkg::OP_W-1:0]    s_axis_tuser,  // operation[1:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [skt_pkg::OUT_DW-1:0]  m_axis_tdata,  // position[3:0], entry_count[8:4], zeros
    output logic [skt_pkg::STAT_W-1:0]  m_axis_tuser   // status[1:0]
);
    import skt_pkg::*;

    `include "sorted_key_table_macros.svh"

    t_state                  r_state;
    t_state                  n_state;
    t_op                     r_op;
    logic signed [KEY_W-1:0] r_key;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;

    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_out_status;
    logic [POS_W-1:0]        r_out_pos;
    logic [COUNT_W-1:0]      r_out_cnt;

    t_cell_ctl               w_ctl;
    logic                    w_commit;
    logic                    w_full;
    logic                    w_found;
    logic [STAT_W-1:0]       w_status;
    logic [POS_W-1:0]        w_pos;
    logic [POS_W-1:0]        w_bnd_pos;

    logic signed [KEY_W-1:0] w_cell_key [CAPACITY];
    logic [CAPACITY-1:0]     w_occ;
    logic [CAPACITY-1:0]     w_lt;
    logic [CAPACITY-1:0]     w_eq;
    logic [CAPACITY-1:0]     w_bnd;

    assign w_full = (r_count == CNT_W'(CAPACITY));

    // row of cells, each linked to its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                    w_prev_lt;
        logic signed [KEY_W-1:0] w_left;
        logic signed [KEY_W-1:0] w_right;

        assign w_occ[g] = (r_count > CNT_W'(g));

        if (g == 0) begin : g_first
            assign w_prev_lt = 1'b1;
            assign w_left    = r_key;
        end else begin : g_mid
            assign w_prev_lt = w_lt[g-1];
            assign w_left    = w_cell_key[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_cell_key[g];
        end else begin : g_inner
            assign w_right = w_cell_key[g+1];
        end

        skt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_occ       (w_occ[g]),
            .i_key       (r_key),
            .i_left_key  (w_left),
            .i_right_key (w_right),
            .i_prev_lt   (w_prev_lt),
            .o_key       (w_cell_key[g]),
            .o_lt        (w_lt[g]),
            .o_eq        (w_eq[g]),
            .o_bnd       (w_bnd[g])
        );
    end

    // index of the boundary cell, masked to the field width
    always_comb begin
        w_bnd_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_bnd[i]) begin
                w_bnd_pos = w_bnd_pos | POS_W'(i);
            end
        end
    end

    assign w_found = |(w_bnd & w_eq);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, cell control and result
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_commit      = 1'b0;
        w_ctl         = '0;
        w_status      = ST_OK;
        w_pos         = '0;
        n_count       = r_count;
        unique case (r_op)
            OP_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_pos   = w_bnd_pos;
                    n_count = r_count + 1'b1;
                end
            end
            OP_SEARCH: begin
                if (w_found) begin
                    w_pos = w_bnd_pos;
                end else begin
                    w_status = ST_NOTFOUND;
                end
            end
            OP_DELETE: begin
                if (w_found) begin
                    w_pos   = w_bnd_pos;
                    n_count = r_count - 1'b1;
                end else begin
                    w_status = ST_NOTFOUND;
                end
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                w_ctl.cmp = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_commit  = 1'b1;
                    w_ctl.ins = (r_op == OP_INSERT) && !w_full;
                    w_ctl.del = (r_op == OP_DELETE) && w_found;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_op  <= t_op'(s_axis_tuser);
            r_key <= s_axis_tdata[KEY_W-1:0];
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_commit) begin
            r_count <= n_count;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_status <= w_status;
            r_out_pos    <= w_pos;
            r_out_cnt    <= COUNT_W'(n_count);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {(OUT_DW - POS_W - COUNT_W)'(0), r_out_cnt, r_out_pos};

    // checks on the row and the sequencer
    `SKT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY),
        "entry count above capacity")
    `SKT_ASSERT_NOW(a_one_boundary, r_state == S_UPD, $onehot0(w_bnd),
        "more than one boundary cell in the row")
    `SKT_ASSERT_NOW(a_full_count, w_commit && w_status == ST_FULL, w_full,
        "full status with free cells")
    `SKT_ASSERT_NEXT(a_accept_cmp, s_axis_tvalid && s_axis_tready, r_state == S_CMP,
        "accepted item did not start a compare")

endmodule

// ----- tb/sv/sorted_key_table_test.sv -----
// self-checking bench for sorted_key_table: directed corner items, then random
// insert/search/delete/clear traffic under varying stream back-pressure
// depends on skt_pkg and the sorted_key_table rtl
`timescale 1ns / 1ps

module sorted_key_table_test;

    import skt_pkg::*;

    // one predicted result item
    typedef struct {
        logic [STAT_W-1:0]  status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] entry_count;
    } t_outcome;

    // mirror of the sorted table and the queue of outcomes it predicts
    class sorted_table_tracker;
        int       table_keys[$];
        t_outcome pending_outcomes[$];
        int       mismatches;
        int       responses_checked;
        int       op_seen[4];
        int       status_seen[3];

        // update the mirror for an accepted item and queue its outcome
        function void accept_request(t_op op, logic [KEY_W-1:0] raw_key);
            t_outcome expd;
            int       k;
            int       slot;
            k    = $signed(raw_key);
            slot = 0;
            // first slot whose key is not smaller
            while (slot < table_keys.size() && table_keys[slot] < k)
                slot++;
            expd.status   = ST_OK;
            expd.position = '0;
            case (op)
                OP_INSERT: begin
                    if (table_keys.size() >= CAPACITY) begin
                        expd.status = ST_FULL;
                    end else begin
                        table_keys.insert(slot, k);
                        expd.position = POS_W'(slot);
                    end
                end
                OP_SEARCH: begin
                    if (slot < table_keys.size() && table_keys[slot] == k)
                        expd.position = POS_W'(slot);
                    else
                        expd.status = ST_NOTFOUND;
                end
                OP_DELETE: begin
                    if (slot < table_keys.size() && table_keys[slot] == k) begin
                        table_keys.delete(slot);
                        expd.position = POS_W'(slot);
                    end else begin
                        expd.status = ST_NOTFOUND;
                    end
                end
                default: table_keys.delete();
            endcase
            expd.entry_count = COUNT_W'(table_keys.size());
            op_seen[op]++;
            pending_outcomes.push_back(expd);
        endfunction

        // compare one result item with the oldest prediction
        function void check_response(logic [STAT_W-1:0] status,
                                     logic [POS_W-1:0] position,
                                     logic [COUNT_W-1:0] entry_count);
            t_outcome expd;
            if (pending_outcomes.size() == 0) begin
                $error("result item with nothing pending: status %0d position %0d count %0d",
                       status, position, entry_count);
                mismatches++;
                return;
            end
            expd = pending_outcomes.pop_front();
            responses_checked++;
            if (expd.status < 3)
                status_seen[expd.status]++;
            if (status !== expd.status) begin
                $error("status: expected %0d, got %0d", expd.status, status);
                mismatches++;
            end
            if (position !== expd.position) begin
                $error("position: expected %0d, got %0d", expd.position, position);
                mismatches++;
            end
            if (entry_count !== expd.entry_count) begin
                $error("entry_count: expected %0d, got %0d", expd.entry_count, entry_count);
                mismatches++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_DW-1:0]    s_axis_tdata;   // key[31:0]
    logic [OP_W-1:0]     s_axis_tuser;   // operation[1:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_DW-1:0]   m_axis_tdata;   // position[3:0], entry_count[8:4], zeros
    logic [STAT_W-1:0]   m_axis_tuser;   // status[1:0]

    sorted_table_tracker tracker = new();
    int                  tx_idle_pct;
    int                  rx_idle_pct;

    sorted_key_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 100 MHz clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check accepted items, random back-pressure
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_response(m_axis_tuser, m_axis_tdata[POS_W-1:0],
                                   m_axis_tdata[POS_W+COUNT_W-1:POS_W]);
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // present one item, with random idle cycles ahead of it
    task automatic send_request(t_op op, logic [KEY_W-1:0] key);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.accept_request(op, key);
    endtask

    // mostly keys already stored or small ones near zero, so hits and duplicates are common
    function automatic logic [KEY_W-1:0] choose_key();
        int r;
        r = $urandom_range(99);
        if (r < 45 && tracker.table_keys.size() > 0)
            return tracker.table_keys[$urandom_range(tracker.table_keys.size() - 1)];
        if (r < 75)
            return KEY_W'($signed($urandom_range(16)) - 8);
        if (r < 85) begin
            case ($urandom_range(3))
                0: return 32'h7fff_ffff;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    // operation mix per traffic style: fill burst, insert-heavy, drain, mixed
    function automatic t_op choose_op(int style);
        int r;
        r = $urandom_range(99);
        case (style)
            0: return OP_INSERT;
            1: return (r < 70) ? OP_INSERT : (r < 85) ? OP_SEARCH :
                      (r < 99) ? OP_DELETE : OP_CLEAR;
            2: return (r < 60) ? OP_DELETE : (r < 80) ? OP_SEARCH : OP_INSERT;
            default: return (r < 35) ? OP_INSERT : (r < 65) ? OP_SEARCH :
                            (r < 95) ? OP_DELETE : OP_CLEAR;
        endcase
    endfunction

    // run random episodes until the phase has sent its share of items
    task automatic random_phase(int n_items);
        int sent;
        int style;
        int run_len;
        sent  = 0;
        style = 0;
        while (sent < n_items) begin
            run_len = (style == 0) ? $urandom_range(20, 17) : $urandom_range(40, 10);
            repeat (run_len) begin
                send_request(choose_op(style), choose_key());
                sent++;
            end
            style = $urandom_range(3);
        end
    endtask

    // directed corners, then three back-pressure phases
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_INSERT;
        m_axis_tready = 1'b0;
        tx_idle_pct   = 20;
        rx_idle_pct   = 84;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, a duplicate, hits and misses on every lookup
        send_request(OP_INSERT, 32'h7fff_ffff);
        send_request(OP_INSERT, 32'h8000_0000);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'h0000_0000);
        send_request(OP_INSERT, 32'hffff_ffff);
        send_request(OP_SEARCH, 32'h0000_0000);
        send_request(OP_SEARCH, 32'h8000_0000);
        send_request(OP_SEARCH, 32'h7fff_ffff);
        send_request(OP_SEARCH, 32'h0000_0001);
        send_request(OP_DELETE, 32'h0000_0000);
        send_request(OP_DELETE, 32'h0000_0001);
        send_request(OP_SEARCH, 32'h0000_0000);
        send_request(OP_CLEAR,  32'hdead_beef);
        // lookups on an empty table
        send_request(OP_SEARCH, 32'h0000_0000);
        send_request(OP_DELETE, 32'h0000_0000);
        // removing the only key leaves the table empty
        send_request(OP_INSERT, 32'h5555_5555);
        send_request(OP_DELETE, 32'h5555_5555);
        send_request(OP_INSERT, 32'haaaa_aaaa);
        send_request(OP_CLEAR,  32'h0000_0000);

        random_phase(450);
        tx_idle_pct = 84;
        rx_idle_pct = 20;
        random_phase(450);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_phase(450);
        s_axis_tvalid <= 1'b0;

        // drain, then a few quiet cycles to catch stray results
        while (tracker.pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("tb: %0d results checked: %0d inserts, %0d searches, %0d deletes, %0d clears",
                 tracker.responses_checked, tracker.op_seen[OP_INSERT],
                 tracker.op_seen[OP_SEARCH], tracker.op_seen[OP_DELETE],
                 tracker.op_seen[OP_CLEAR]);
        $display("tb: %0d done or found, %0d not found, %0d refused on a full table",
                 tracker.status_seen[ST_OK], tracker.status_seen[ST_NOTFOUND],
                 tracker.status_seen[ST_FULL]);
        if (tracker.mismatches == 0 && tracker.pending_outcomes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
